// ----- rtl/core/rwf_pkg.sv -----
// Shared types and constants for the right wall follow controller.
// No dependencies; imported by every module of the core.
`default_nettype none

package rwf_pkg;

  // Sensor reading at or above this counts as no wall (Q8.4)
  localparam logic [16:0] SensorMax        = 17'd4000;
  localparam logic [9:0]  TurnSpeed        = 10'd352;
  localparam logic [9:0]  SearchOuterSpeed = 10'd560;
  localparam logic [9:0]  SearchInnerSpeed = 10'd160;
  // sin(45 deg) in Q0.16
  localparam logic [15:0] Sin45Q16         = 16'd46341;

  localparam logic [1:0] MODE_FOLLOW = 2'd0;
  localparam logic [1:0] MODE_TURN   = 2'd1;
  localparam logic [1:0] MODE_SEARCH = 2'd2;

  localparam logic [2:0] REG_TARGET   = 3'd0;
  localparam logic [2:0] REG_CORNER   = 3'd1;
  localparam logic [2:0] REG_LOST     = 3'd2;
  localparam logic [2:0] REG_CRUISE   = 3'd3;
  localparam logic [2:0] REG_DGAIN    = 3'd4;
  localparam logic [2:0] REG_HGAIN    = 3'd5;
  localparam logic [2:0] REG_MAXCORR  = 3'd6;
  localparam logic [2:0] REG_RECOVERY = 3'd7;

  localparam int unsigned AddrWidth = 5;

  typedef struct packed {
    logic [11:0] target_distance;
    logic [11:0] corner_distance;
    logic [11:0] lost_distance;
    logic [9:0]  cruise_speed;
    logic [7:0]  distance_gain;
    logic [7:0]  heading_gain;
    logic [9:0]  max_correction;
    logic [7:0]  recovery_ticks;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    target_distance: 12'd432,
    corner_distance: 12'd512,
    lost_distance:   12'd1200,
    cruise_speed:    10'd560,
    distance_gain:   8'd77,
    heading_gain:    8'd51,
    max_correction:  10'd288,
    recovery_ticks:  8'd24
  };

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;    // capture request, decide mode, step countdown
    logic calc_dist;  // projection and distance term
    logic calc_head;  // heading term
    logic load_out;   // clamp, form speeds, fill output register
  } cmd_t;

endpackage : rwf_pkg

`default_nettype wire

// ----- rtl/core/rwf_regs.sv -----
// APB-style configuration register file for the wall follow controller.
// Depends on rwf_pkg.
`default_nettype none

module rwf_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rwf_pkg::AddrWidth-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  output rwf_pkg::cfg_t                      cfg_o
);
  import rwf_pkg::*;

  cfg_t        cfg_q, cfg_d;
  logic [2:0]  idx;
  logic        wr_en;

  assign idx    = paddr[AddrWidth-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_TARGET:   cfg_d.target_distance = pwdata[11:0];
        REG_CORNER:   cfg_d.corner_distance = pwdata[11:0];
        REG_LOST:     cfg_d.lost_distance   = pwdata[11:0];
        REG_CRUISE:   cfg_d.cruise_speed    = pwdata[9:0];
        REG_DGAIN:    cfg_d.distance_gain   = pwdata[7:0];
        REG_HGAIN:    cfg_d.heading_gain    = pwdata[7:0];
        REG_MAXCORR:  cfg_d.max_correction  = pwdata[9:0];
        REG_RECOVERY: cfg_d.recovery_ticks  = pwdata[7:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      REG_TARGET:   prdata = {20'd0, cfg_q.target_distance};
      REG_CORNER:   prdata = {20'd0, cfg_q.corner_distance};
      REG_LOST:     prdata = {20'd0, cfg_q.lost_distance};
      REG_CRUISE:   prdata = {22'd0, cfg_q.cruise_speed};
      REG_DGAIN:    prdata = {24'd0, cfg_q.distance_gain};
      REG_HGAIN:    prdata = {24'd0, cfg_q.heading_gain};
      REG_MAXCORR:  prdata = {22'd0, cfg_q.max_correction};
      REG_RECOVERY: prdata = {24'd0, cfg_q.recovery_ticks};
      default:      prdata = 32'd0;
    endcase
  end

endmodule : rwf_regs

`default_nettype wire

// ----- rtl/core/rwf_ctrl.sv -----
// Sequencing state machine for the wall follow controller.
// Depends on rwf_pkg; drives the datapath through cmd_t.
`default_nettype none

module rwf_ctrl (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output rwf_pkg::cmd_t cmd_o
);
  import rwf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIST = 2'd1;
  localparam logic [1:0] ST_HEAD = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // Output register frees up when empty or being taken this cycle
  assign out_free    = ~out_valid_q | out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d        = state_q;
    out_valid_d    = out_valid_q & ~out_ready_i;
    cmd_o          = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_DIST;
        end
      end
      ST_DIST: begin
        cmd_o.calc_dist = 1'b1;
        state_d         = ST_HEAD;
      end
      ST_HEAD: begin
        cmd_o.calc_head = 1'b1;
        state_d         = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule : rwf_ctrl

`default_nettype wire

// ----- rtl/core/rwf_dp.sv -----
// Datapath: mode decision, recovery countdown, proportional steering math.
// Depends on rwf_pkg; sequenced by rwf_ctrl through cmd_t.
`default_nettype none

module rwf_dp (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire rwf_pkg::cfg_t cfg_i,
  input  wire rwf_pkg::cmd_t cmd_i,
  input  wire logic [11:0]   right_distance_i,
  input  wire logic [11:0]   front_right_distance_i,
  input  wire logic          collided_i,
  output logic signed [11:0] left_speed_o,
  output logic signed [11:0] right_speed_o,
  output logic        [1:0]  control_state_o
);
  import rwf_pkg::*;

  logic        [7:0]  rec_q, rec_d;
  logic        [7:0]  rec_eff;
  logic        [1:0]  mode_now;
  logic               front_now, right_now;

  logic        [11:0] rd_q, fr_q;
  logic               front_q;
  logic        [1:0]  mode_q;

  logic        [27:0] proj_prod;
  logic        [11:0] proj_q;
  logic signed [12:0] dist_err, head_err;
  logic signed [21:0] dist_prod, head_prod;
  logic signed [15:0] dterm_q, hterm_q;

  logic signed [16:0] corr_sum, lim_pos, lim_neg, corr_clip;
  logic signed [11:0] corr_ext, cruise_s, turn_s;
  logic signed [11:0] ls_d, rs_d;
  logic signed [11:0] ls_q, rs_q;
  logic        [1:0]  mode_out_q;

  // Mode decision on the request as it arrives
  always_comb begin
    front_now = {5'd0, front_right_distance_i} < SensorMax;
    right_now = {5'd0, right_distance_i} < SensorMax;
    rec_eff   = collided_i ? cfg_i.recovery_ticks : rec_q;
    rec_d     = rec_q;
    if (rec_eff != 8'd0) begin
      mode_now = MODE_TURN;
      rec_d    = rec_eff - 8'd1;
    end else begin
      rec_d = 8'd0;
      if (front_now && (front_right_distance_i < cfg_i.corner_distance)) begin
        mode_now = MODE_TURN;
      end else if (!right_now || (right_distance_i > cfg_i.lost_distance)) begin
        mode_now = MODE_SEARCH;
      end else begin
        mode_now = MODE_FOLLOW;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= 8'd0;
    end else if (cmd_i.load_in) begin
      rec_q <= rec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      rd_q    <= right_distance_i;
      fr_q    <= front_right_distance_i;
      front_q <= front_now;
      mode_q  <= mode_now;
    end
  end

  // Projection and distance term; products floored by taking the upper bits
  assign proj_prod = 28'(fr_q * Sin45Q16);
  assign dist_err  = $signed({1'b0, cfg_i.target_distance}) - $signed({1'b0, rd_q});
  assign dist_prod = $signed({1'b0, cfg_i.distance_gain}) * dist_err;

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_dist) begin
      proj_q  <= proj_prod[27:16];
      dterm_q <= dist_prod[21:6];
    end
  end

  assign head_err  = $signed({1'b0, rd_q}) - $signed({1'b0, proj_q});
  assign head_prod = $signed({1'b0, cfg_i.heading_gain}) * head_err;

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_head) begin
      hterm_q <= front_q ? head_prod[21:6] : 16'sd0;
    end
  end

  // Clamp and differential speeds
  always_comb begin
    corr_sum = 17'(dterm_q) + 17'(hterm_q);
    lim_pos  = $signed({7'd0, cfg_i.max_correction});
    lim_neg  = -lim_pos;
    if (corr_sum > lim_pos) begin
      corr_clip = lim_pos;
    end else if (corr_sum < lim_neg) begin
      corr_clip = lim_neg;
    end else begin
      corr_clip = corr_sum;
    end
    corr_ext = corr_clip[11:0];
    cruise_s = $signed({2'd0, cfg_i.cruise_speed});
    turn_s   = $signed({2'd0, TurnSpeed});
    case (mode_q)
      MODE_TURN: begin
        ls_d = -turn_s;
        rs_d = turn_s;
      end
      MODE_SEARCH: begin
        ls_d = $signed({2'd0, SearchOuterSpeed});
        rs_d = $signed({2'd0, SearchInnerSpeed});
      end
      default: begin
        ls_d = cruise_s - corr_ext;
        rs_d = cruise_s + corr_ext;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      ls_q       <= ls_d;
      rs_q       <= rs_d;
      mode_out_q <= mode_q;
    end
  end

  assign left_speed_o    = ls_q;
  assign right_speed_o   = rs_q;
  assign control_state_o = mode_out_q;

endmodule : rwf_dp

`default_nettype wire

// ----- rtl/core/right_wall_follow_controller_core.sv -----
// Right wall follow controller, top level.
// Requests are taken one at a time: a new request is accepted only once the previous
// one has passed through the four-step sequence (decide, distance term, heading term,
// clamp), which shares one set of datapath registers, and its result has been loaded.
// Reset: asynchronous active low; config returns to defaults, recovery count clears.
// Depends on rwf_pkg, rwf_regs, rwf_ctrl, rwf_dp.
`default_nettype none

module right_wall_follow_controller_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // request channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [11:0]                   right_distance_i,
  input  wire logic [11:0]                   front_right_distance_i,
  input  wire logic                          collided_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [11:0]                 left_speed_o,
  output logic signed [11:0]                 right_speed_o,
  output logic        [1:0]                  control_state_o,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rwf_pkg::AddrWidth-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);
  import rwf_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  rwf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rwf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  rwf_dp u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_i                  (cfg),
    .cmd_i                  (cmd),
    .right_distance_i       (right_distance_i),
    .front_right_distance_i (front_right_distance_i),
    .collided_i             (collided_i),
    .left_speed_o           (left_speed_o),
    .right_speed_o          (right_speed_o),
    .control_state_o        (control_state_o)
  );

endmodule : right_wall_follow_controller_core

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking bench for right_wall_follow_controller_core: sensor requests in, wheel commands out.
// A local steering predictor checks each result; config is programmed over APB between phases.
// Depends on rwf_pkg and the core RTL.
`timescale 1ns / 100ps

module testbench;
  import rwf_pkg::*;

  localparam int NumRegs       = 8;
  localparam int NumPhases     = 8;
  localparam int PhaseItems    = 120;
  localparam int DutLatency    = 4;
  localparam int HoldOffCycles = 400;
  localparam int WatchdogLimit = 4000;
  localparam int PrintCap      = 100;

  localparam logic [31:0] RegMax [NumRegs] = '{4095, 4095, 4095, 1023, 255, 255, 1023, 255};
  localparam logic [31:0] RegRst [NumRegs] = '{432, 512, 1200, 560, 77, 51, 288, 24};

  typedef struct packed {
    logic [11:0] right_dist;
    logic [11:0] front_dist;
    logic        bump;
  } reading_t;

  typedef struct packed {
    logic [11:0] left_spd;
    logic [11:0] right_spd;
    logic [1:0]  mode;
  } wheel_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [11:0] right_distance = '0;
  logic [11:0] front_right_distance = '0;
  logic        collided = 1'b0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [11:0] left_speed;
  logic signed [11:0] right_speed;
  logic [1:0]         control_state;

  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  reading_t   reading_q[$];
  wheel_cmd_t wheel_cmd_q[$];

  cfg_t       cfg_model = CfgReset;
  logic [7:0] spin_left = 8'd0;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  logic rx_hold = 1'b0;
  logic pressure_go = 1'b0;

  int mismatches = 0;
  int n_requests = 0;
  int n_results = 0;
  int n_settings = 0;
  int quiet_cycles = 0;
  int mode_hits [4] = '{0, 0, 0, 0};

  right_wall_follow_controller_core u_dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid),
    .in_ready_o             (in_ready),
    .right_distance_i       (right_distance),
    .front_right_distance_i (front_right_distance),
    .collided_i             (collided),
    .out_valid_o            (out_valid),
    .out_ready_i            (out_ready),
    .left_speed_o           (left_speed),
    .right_speed_o          (right_speed),
    .control_state_o        (control_state),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready)
  );

  always #1 clk_i = ~clk_i;

  task automatic log_mismatch(input string msg);
    if (mismatches < PrintCap) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
    mismatches++;
  endtask

  // Steering law; also advances the recovery countdown
  function automatic wheel_cmd_t predict_wheel_cmd(logic [11:0] rd, logic [11:0] fr, logic bump);
    wheel_cmd_t cmd;
    logic       right_seen;
    logic       front_seen;
    logic [1:0] mode;
    int         corr;
    int         lim;
    int         proj;
    int         ls;
    int         rs;
    right_seen = ({5'd0, rd} < SensorMax);
    front_seen = ({5'd0, fr} < SensorMax);
    if (bump) spin_left = cfg_model.recovery_ticks;
    if (spin_left != 8'd0) begin
      mode = MODE_TURN;
      spin_left = spin_left - 8'd1;
    end else if (front_seen && fr < cfg_model.corner_distance) begin
      mode = MODE_TURN;
    end else if (!right_seen || rd > cfg_model.lost_distance) begin
      mode = MODE_SEARCH;
    end else begin
      mode = MODE_FOLLOW;
    end
    case (mode)
      MODE_TURN: begin
        ls = -int'(TurnSpeed);
        rs = int'(TurnSpeed);
      end
      MODE_SEARCH: begin
        ls = int'(SearchOuterSpeed);
        rs = int'(SearchInnerSpeed);
      end
      default: begin
        // >>> on int floors toward minus infinity
        corr = (int'(cfg_model.distance_gain) *
                (int'(cfg_model.target_distance) - int'(rd))) >>> 6;
        if (front_seen) begin
          proj = int'((longint'(fr) * longint'(Sin45Q16)) >> 16);
          corr += (int'(cfg_model.heading_gain) * (int'(rd) - proj)) >>> 6;
        end
        lim = int'(cfg_model.max_correction);
        if (corr > lim) corr = lim;
        else if (corr < -lim) corr = -lim;
        ls = int'(cfg_model.cruise_speed) - corr;
        rs = int'(cfg_model.cruise_speed) + corr;
      end
    endcase
    cmd.left_spd  = ls[11:0];
    cmd.right_spd = rs[11:0];
    cmd.mode      = mode;
    return cmd;
  endfunction

  // Request driver
  always @(posedge clk_i) begin : driver
    reading_t nxt;
    if (in_valid && in_ready) begin
      wheel_cmd_q.push_back(predict_wheel_cmd(right_distance, front_right_distance, collided));
      n_requests++;
    end
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (reading_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt = reading_q.pop_front();
        in_valid             <= 1'b1;
        right_distance       <= nxt.right_dist;
        front_right_distance <= nxt.front_dist;
        collided             <= nxt.bump;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin : monitor
    wheel_cmd_t want;
    if (out_valid && out_ready) begin
      n_results++;
      if (wheel_cmd_q.size() == 0) begin
        log_mismatch("wheel result with no request outstanding");
      end else begin
        want = wheel_cmd_q.pop_front();
        mode_hits[want.mode]++;
        if (left_speed !== want.left_spd)
          log_mismatch($sformatf("left_speed got %0d want %0d",
                                 left_speed, $signed(want.left_spd)));
        if (right_speed !== want.right_spd)
          log_mismatch($sformatf("right_speed got %0d want %0d",
                                 right_speed, $signed(want.right_spd)));
        if (control_state !== want.mode)
          log_mismatch($sformatf("control_state got %0d want %0d", control_state, want.mode));
      end
    end
    out_ready <= rst_ni && !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  // Long receiver hold-off so the core backs up and stalls its input
  initial begin : rx_pressure
    wait (pressure_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HoldOffCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || psel || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic apb_transfer(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write a register, mirror it in the model, read it back
  task automatic program_reg(input logic [2:0] idx, input logic [31:0] val);
    logic [31:0] unused_rd;
    logic [31:0] readback;
    logic [31:0] held;
    apb_transfer(1'b1, idx, val, unused_rd);
    case (idx)
      REG_TARGET:   begin cfg_model.target_distance = val[11:0]; held = {20'd0, val[11:0]}; end
      REG_CORNER:   begin cfg_model.corner_distance = val[11:0]; held = {20'd0, val[11:0]}; end
      REG_LOST:     begin cfg_model.lost_distance   = val[11:0]; held = {20'd0, val[11:0]}; end
      REG_CRUISE:   begin cfg_model.cruise_speed    = val[9:0];  held = {22'd0, val[9:0]};  end
      REG_DGAIN:    begin cfg_model.distance_gain   = val[7:0];  held = {24'd0, val[7:0]};  end
      REG_HGAIN:    begin cfg_model.heading_gain    = val[7:0];  held = {24'd0, val[7:0]};  end
      REG_MAXCORR:  begin cfg_model.max_correction  = val[9:0];  held = {22'd0, val[9:0]};  end
      default:      begin cfg_model.recovery_ticks  = val[7:0];  held = {24'd0, val[7:0]};  end
    endcase
    apb_transfer(1'b0, idx, 32'd0, readback);
    if (readback !== held)
      log_mismatch($sformatf("reg %0d readback 0x%0h want 0x%0h", idx, readback, held));
  endtask

  task automatic queue_reading(input logic [11:0] rd, input logic [11:0] fr, input logic bump);
    reading_q.push_back('{rd, fr, bump});
  endtask

  // Mostly plausible wall geometry around the target, plus noise and no-wall readings
  task automatic queue_random_readings(input int count);
    int rd;
    int fr;
    int kind;
    for (int k = 0; k < count; k++) begin
      kind = $urandom_range(99);
      if (kind < 10) begin
        rd = $urandom_range(4095);
        fr = $urandom_range(4095);
      end else if (kind < 20) begin
        rd = $urandom_range(3990, 4095);
        fr = ($urandom_range(99) < 50) ? $urandom_range(3990, 4095) : $urandom_range(4095);
      end else begin
        rd = int'(cfg_model.target_distance) + int'($urandom_range(600)) - 300;
        kind = $urandom_range(99);
        if (kind < 20) fr = $urandom_range(4000, 4095);
        else if (kind < 35) fr = int'(cfg_model.corner_distance) + int'($urandom_range(40)) - 20;
        else fr = (rd * 181) / 128 + int'($urandom_range(400)) - 200;
      end
      if (rd < 0) rd = 0;
      if (rd > 4095) rd = 4095;
      if (fr < 0) fr = 0;
      if (fr > 4095) fr = 4095;
      queue_reading(rd[11:0], fr[11:0], $urandom_range(99) < 4);
    end
  endtask

  task automatic wait_drained();
    while (reading_q.size() != 0 || in_valid || wheel_cmd_q.size() != 0) @(negedge clk_i);
    repeat (2 * DutLatency) @(negedge clk_i);
  endtask

  initial begin : main
    logic [31:0] val;
    logic [31:0] hi;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: field extremes, each mode, boundaries, collision and reload
    queue_reading(12'd432,  12'd4000, 1'b0);  // on target, front absent
    queue_reading(12'd0,    12'd4000, 1'b0);  // hugging wall, clamps
    queue_reading(12'd1200, 12'd4095, 1'b0);  // at lost distance, still following
    queue_reading(12'd1201, 12'd4000, 1'b0);  // just past lost distance
    queue_reading(12'd4000, 12'd4000, 1'b0);  // no walls at all
    queue_reading(12'd4095, 12'd0,    1'b0);  // front-right blocked
    queue_reading(12'd500,  12'd511,  1'b0);  // just inside corner distance
    queue_reading(12'd500,  12'd512,  1'b0);  // at corner distance, heading term
    queue_reading(12'd600,  12'd900,  1'b0);
    queue_reading(12'd3999, 12'd3999, 1'b0);
    queue_reading(12'd0,    12'd3999, 1'b0);
    queue_reading(12'd1000, 12'd1414, 1'b0);
    queue_reading(12'd300,  12'd2000, 1'b0);
    queue_reading(12'd432,  12'd4000, 1'b1);  // collision starts recovery spin
    queue_reading(12'd432,  12'd4000, 1'b0);
    queue_reading(12'd2048, 12'd2048, 1'b0);
    queue_reading(12'd432,  12'd610,  1'b1);  // collision during recovery reloads
    queue_reading(12'd1365, 12'd2730, 1'b0);
    queue_reading(12'd4095, 12'd4095, 1'b1);
    queue_reading(12'd2730, 12'd1365, 1'b0);
    wait_drained();

    for (int p = 0; p < NumPhases; p++) begin
      for (int r = 0; r < NumRegs; r++) begin
        hi = (RegRst[r] * 2 > RegMax[r]) ? RegMax[r] : RegRst[r] * 2;
        case (p)
          0:       val = RegMax[r];
          1:       val = 32'd0;
          2:       val = RegRst[r];
          4:       val = $urandom_range(hi, RegRst[r] / 2);
          default: val = $urandom();
        endcase
        program_reg(3'(r), val);
      end
      n_settings++;
      @(negedge clk_i);
      case (p % 4)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 64; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 64; end
        default: begin tx_idle_pct = 27; rx_stall_pct = 27; end
      endcase
      queue_random_readings(PhaseItems);
      if (p == 2) pressure_go = 1'b1;
      wait_drained();
    end

    repeat (4 * DutLatency) @(negedge clk_i);
    if (wheel_cmd_q.size() != 0)
      log_mismatch($sformatf("%0d wheel results never arrived", wheel_cmd_q.size()));

    $display("Run: %0d sensor requests, %0d wheel results, %0d register settings, %0d mismatches",
             n_requests, n_results, n_settings, mismatches);
    $display("Results by mode: follow %0d, turn %0d, search %0d",
             mode_hits[MODE_FOLLOW], mode_hits[MODE_TURN], mode_hits[MODE_SEARCH]);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
